/* sv/packed_raw_sample_unpacker_defines.svh */
// Assertion macros used by the checker file.
`ifndef PACKED_RAW_SAMPLE_UNPACKER_DEFINES_SVH
`define PACKED_RAW_SAMPLE_UNPACKER_DEFINES_SVH

// Checked on every edge outside reset.
`define PRSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PRSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/prsu_pkg.sv */
package prsu_pkg;

  localparam int MAX_WIDTH  = 8192;
  localparam int MAX_HEIGHT = 8192;
  // must be a power of two
  localparam int LINE_ALIGN = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [13:0] MAX_W      = 14'(MAX_WIDTH);
  localparam logic [13:0] MAX_H      = 14'(MAX_HEIGHT);
  localparam logic [14:0] ALIGN_MASK = 15'(LINE_ALIGN - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PACK_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TWELVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 2'd3;

  // pack modes
  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_MIPI  = 2'd1;
  localparam logic [1:0] MODE_LSB   = 2'd2;

  typedef struct packed {
    logic [1:0]  pack_mode;
    logic        depth_is_twelve;
    logic [13:0] width_pixels;
    logic [13:0] height_lines;
  } cfg_t;

  // one decoded group: up to four samples, last_idx is count minus one
  typedef struct packed {
    logic [3:0][15:0] samples;
    logic [1:0]       last_idx;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } q_rd_t;

  function automatic logic is_packed(logic [1:0] m);
    return (m == MODE_MIPI) || (m == MODE_LSB);
  endfunction

  function automatic logic [13:0] eff_width(cfg_t c);
    logic [13:0] wc;
    logic [13:0] wm;
    wc = (c.width_pixels > MAX_W) ? MAX_W : c.width_pixels;
    wm = wc;
    if (!is_packed(c.pack_mode)) begin
      if (wc == 14'd0) wm = 14'd1;
    end else if (c.depth_is_twelve) begin
      wm = {wc[13:1], 1'b0};
      if (wm < 14'd2) wm = 14'd2;
    end else begin
      wm = {wc[13:2], 2'b00};
      if (wm < 14'd4) wm = 14'd4;
    end
    return wm;
  endfunction

  function automatic logic [13:0] eff_height(cfg_t c);
    logic [13:0] h;
    h = c.height_lines;
    if (h == 14'd0) h = 14'd1;
    if (h > MAX_H) h = MAX_H;
    return h;
  endfunction

  // data bytes per line in packed modes: groups times bytes per group
  function automatic logic [14:0] line_bytes(cfg_t c);
    logic [14:0] w;
    w = 15'(eff_width(c));
    return c.depth_is_twelve ? (w + (w >> 1)) : (w + (w >> 2));
  endfunction

  function automatic logic [3:0][15:0] unpack_group(logic [31:0] gb, logic [7:0] b,
                                                    logic twelve, logic mipi);
    logic [3:0][15:0] s;
    logic [7:0] b0, b1, b2, b3;
    b0 = gb[7:0];
    b1 = gb[15:8];
    b2 = gb[23:16];
    b3 = gb[31:24];
    s  = '0;
    if (twelve) begin
      if (mipi) begin
        s[0] = {4'd0, b0, b[3:0]};
        s[1] = {4'd0, b1, b[7:4]};
      end else begin
        s[0] = {4'd0, b1[3:0], b0};
        s[1] = {4'd0, b, b1[7:4]};
      end
    end else begin
      if (mipi) begin
        s[0] = {6'd0, b0, b[1:0]};
        s[1] = {6'd0, b1, b[3:2]};
        s[2] = {6'd0, b2, b[5:4]};
        s[3] = {6'd0, b3, b[7:6]};
      end else begin
        s[0] = {6'd0, b1[1:0], b0};
        s[1] = {6'd0, b2[3:0], b1[7:2]};
        s[2] = {6'd0, b3[5:0], b2[7:4]};
        s[3] = {6'd0, b, b3[7:6]};
      end
    end
    return s;
  endfunction

endpackage

/* sv/prsu_if.sv */
interface prsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface prsu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_value;
  logic        end_of_line;
  logic        end_of_frame;
  logic        last_of_burst;

  modport source (output valid, output sample_value, output end_of_line,
                  output end_of_frame, output last_of_burst, input ready);
  modport sink   (input valid, input sample_value, input end_of_line,
                  input end_of_frame, input last_of_burst, output ready);
endinterface

/* sv/packed_raw_sample_unpacker.sv */
// The first sample of a group is offered once the group's last byte has been
// written to the queue and the sample loaded into the output register.
// Throughput: one byte per cycle in while the queue has room, one sample per cycle
// out while the receiver is ready; a four-entry group queue absorbs bursts.
// Reset: synchronous active-low rst_n empties the queue and clears all counters;
// registers return to pack_mode 1, ten-bit depth, width 1920, height 1080.
module packed_raw_sample_unpacker (
  input  logic                               clk,
  input  logic                               rst_n,
  prsu_in_if.sink                            in_s,
  prsu_out_if.source                         out_s,
  input  logic                               cfg_we,
  input  logic [prsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prsu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import prsu_pkg::*;

  cfg_t  cfg_r;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pack_mode       <= MODE_MIPI;
      cfg_r.depth_is_twelve <= 1'b0;
      cfg_r.width_pixels    <= 14'd1920;
      cfg_r.height_lines    <= 14'd1080;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PACK_MODE:    cfg_r.pack_mode       <= cfg_data[1:0];
        REG_DEPTH_TWELVE: cfg_r.depth_is_twelve <= cfg_data[0];
        REG_WIDTH:        cfg_r.width_pixels    <= cfg_data;
        REG_HEIGHT:       cfg_r.height_lines    <= cfg_data;
        default:          cfg_r                 <= cfg_r;
      endcase
    end
  end

  prsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_s   (in_s),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  prsu_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  prsu_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .q_rd  (q_rd),
    .pop   (pop),
    .out_s (out_s)
  );

endmodule

/* sv/prsu_front.sv */
module prsu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  prsu_pkg::cfg_t cfg,
  prsu_in_if.sink        in_s,
  input  logic           q_full,
  output prsu_pkg::q_wr_t q_wr
);
  import prsu_pkg::*;

  logic [31:0] gb_r, gb_nxt;
  logic [2:0]  big_r, big_nxt;
  logic [13:0] lbc_r, lbc_nxt;

  logic        xfer;
  logic [7:0]  b;
  logic [14:0] line, step, lbc_inc;
  logic [3:0]  gbytes;

  assign in_s.ready = !q_full;
  assign xfer       = in_s.valid && !q_full;
  assign b          = in_s.data_byte;

  assign line    = line_bytes(cfg);
  assign step    = (line + ALIGN_MASK) & ~ALIGN_MASK;
  assign lbc_inc = {1'b0, lbc_r} + 15'd1;
  assign gbytes  = cfg.depth_is_twelve ? 4'd3 : 4'd5;

  always_comb begin
    q_wr    = '0;
    gb_nxt  = gb_r;
    big_nxt = big_r;
    lbc_nxt = lbc_r;
    if (xfer) begin
      if (!is_packed(cfg.pack_mode)) begin
        if (big_r == 3'd0) begin
          gb_nxt  = {24'd0, b};
          big_nxt = 3'd1;
        end else begin
          q_wr.push           = 1'b1;
          q_wr.rec.samples[0] = {b, gb_r[7:0]};
          q_wr.rec.last_idx   = 2'd0;
          gb_nxt              = '0;
          big_nxt             = 3'd0;
        end
      end else begin
        // bytes past the line's data length are padding
        if ({1'b0, lbc_r} < line) begin
          if ({1'b0, big_r} + 4'd1 < gbytes) begin
            gb_nxt  = gb_r | ({24'd0, b} << {big_r[1:0], 3'b000});
            big_nxt = big_r + 3'd1;
          end else begin
            q_wr.push         = 1'b1;
            q_wr.rec.samples  = unpack_group(gb_r, b, cfg.depth_is_twelve,
                                             cfg.pack_mode == MODE_MIPI);
            q_wr.rec.last_idx = cfg.depth_is_twelve ? 2'd1 : 2'd3;
            gb_nxt            = '0;
            big_nxt           = 3'd0;
          end
        end
        lbc_nxt = (lbc_inc >= step) ? 14'd0 : lbc_inc[13:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gb_r  <= '0;
      big_r <= '0;
      lbc_r <= '0;
    end else begin
      gb_r  <= gb_nxt;
      big_r <= big_nxt;
      lbc_r <= lbc_nxt;
    end
  end

endmodule

/* sv/prsu_queue.sv */
module prsu_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  prsu_pkg::q_wr_t q_wr,
  input  logic            pop,
  output logic            full,
  output prsu_pkg::q_rd_t q_rd
);
  import prsu_pkg::*;

  rec_t                mem_r [Q_DEPTH];
  logic [Q_AW-1:0]     wptr_r, rptr_r;
  logic [Q_CW-1:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full       = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_rd.valid = (cnt_r != '0);
  assign q_rd.rec   = mem_r[rptr_r];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + Q_CW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + Q_AW'(1);
      if (do_pop) rptr_r <= rptr_r + Q_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= q_wr.rec;
  end

endmodule

/* sv/prsu_back.sv */
module prsu_back (
  input  logic            clk,
  input  logic            rst_n,
  input  prsu_pkg::cfg_t  cfg,
  input  prsu_pkg::q_rd_t q_rd,
  output logic            pop,
  prsu_out_if.source      out_s
);
  import prsu_pkg::*;

  logic        out_valid_r;
  logic [15:0] sample_r;
  logic        eol_r, eof_r, last_r;
  logic [1:0]  idx_r;
  logic [12:0] col_r, row_r;

  logic        adv, load, eol, eof, last;
  logic [13:0] w, h, col_inc, row_inc;

  assign w       = eff_width(cfg);
  assign h       = eff_height(cfg);
  assign col_inc = {1'b0, col_r} + 14'd1;
  assign row_inc = {1'b0, row_r} + 14'd1;
  assign eol     = col_inc >= w;
  assign eof     = eol && (row_inc >= h);

  assign adv  = !out_valid_r || out_s.ready;
  assign load = adv && q_rd.valid;
  assign last = (idx_r == q_rd.rec.last_idx);
  assign pop  = load && last;

  assign out_s.valid         = out_valid_r;
  assign out_s.sample_value  = sample_r;
  assign out_s.end_of_line   = eol_r;
  assign out_s.end_of_frame  = eof_r;
  assign out_s.last_of_burst = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
    end else if (adv) begin
      out_valid_r <= q_rd.valid;
      if (load) begin
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
        col_r <= eol ? 13'd0 : col_inc[12:0];
        if (eol) row_r <= eof ? 13'd0 : row_inc[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample_r <= q_rd.rec.samples[idx_r];
      eol_r    <= eol;
      eof_r    <= eof;
      last_r   <= last;
    end
  end

endmodule

/* sv/prsu_checker.sv */
`include "packed_raw_sample_unpacker_defines.svh"

module prsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic        out_eol,
  input logic        out_eof,
  input logic        out_last
);

  `PRSU_ASSERT(a_eof_has_eol, out_valid && out_eof |-> out_eol, "end of frame without end of line")
  `PRSU_ASSERT(a_burst_no_gap, out_valid && out_ready && !out_last |=> out_valid, "gap inside a burst")
  `PRSU_ASSERT(a_stall_holds, out_valid && !out_ready |=> out_valid && $stable(out_sample), "stalled sample changed")
  `PRSU_ASSERT_ALWAYS(a_rst_out_idle, !rst_n |=> !out_valid, "output valid after reset")
  `PRSU_ASSERT_ALWAYS(a_rst_in_ready, !rst_n |=> in_ready, "input not ready after reset")

endmodule

bind packed_raw_sample_unpacker prsu_checker u_prsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_s.ready),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .out_sample (out_s.sample_value),
  .out_eol    (out_s.end_of_line),
  .out_eof    (out_s.end_of_frame),
  .out_last   (out_s.last_of_burst)
);

/* verif/tb_top.sv */
module tb_top;
  import prsu_pkg::*;

  // pack mode 3 is not a layout of its own; the block treats it as plain 16-bit
  localparam logic [1:0] MODE_ALIAS_PLAIN = 2'd3;

  localparam int unsigned RANDOM_BYTES  = 80;
  localparam int unsigned FRAME_CAP     = 48;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [15:0] value;
    logic        eol;
    logic        eof;
    logic        last;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  prsu_in_if  in_ch();
  prsu_out_if out_ch();

  packed_raw_sample_unpacker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_ch),
    .out_s     (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block's registers and counters, at their reset values
  logic [1:0]  mode_r   = MODE_MIPI;
  logic        twelve_r = 1'b0;
  logic [13:0] width_r  = 14'd1920;
  logic [13:0] height_r = 14'd1080;
  logic [31:0] grp_bytes = '0;
  logic [2:0]  grp_fill  = '0;
  logic [12:0] col_pos   = '0;
  logic [13:0] line_pos  = '0;
  logic [12:0] row_pos   = '0;

  sample_t expected_samples [$];

  int unsigned burst_left      = 0;
  int unsigned mismatches      = 0;
  int unsigned bytes_sent      = 0;
  int unsigned settings_used   = 0;
  int unsigned samples_checked = 0;
  int unsigned lines_closed    = 0;
  int unsigned frames_closed   = 0;

  function automatic logic mode_is_packed();
    return (mode_r == MODE_MIPI) || (mode_r == MODE_LSB);
  endfunction

  function automatic int unsigned group_samples();
    return twelve_r ? 2 : 4;
  endfunction

  function automatic int unsigned group_len();
    return twelve_r ? 3 : 5;
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_r;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (!mode_is_packed()) begin
      if (w < 1) w = 1;
    end else begin
      w = w - (w % group_samples());
      if (w < group_samples()) w = group_samples();
    end
    return w;
  endfunction

  function automatic int unsigned frame_lines();
    int unsigned h;
    h = height_r;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned data_len();
    return (active_width() / group_samples()) * group_len();
  endfunction

  function automatic int unsigned padded_len();
    return ((data_len() + LINE_ALIGN - 1) / LINE_ALIGN) * LINE_ALIGN;
  endfunction

  task automatic emit_sample(input logic [15:0] value, input int unsigned w, input logic last);
    sample_t s;
    s.value = value;
    s.eol   = 1'b0;
    s.eof   = 1'b0;
    s.last  = last;
    if (32'(col_pos) + 1 >= w) begin
      s.eol   = 1'b1;
      col_pos = '0;
      if (32'(row_pos) + 1 >= frame_lines()) begin
        s.eof   = 1'b1;
        row_pos = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
    expected_samples.push_back(s);
  endtask

  // Advances the shadow state by one accepted byte and queues the samples it completes.
  task automatic absorb_byte(input logic [7:0] b);
    int unsigned w, line_len, nxt;
    logic [15:0] b0, b1, b2, b3, bb;
    logic [15:0] s [4];
    w  = active_width();
    bb = 16'(b);
    if (!mode_is_packed()) begin
      if (grp_fill == 3'd0) begin
        grp_bytes = 32'(b);
        grp_fill  = 3'd1;
      end else begin
        emit_sample({b, grp_bytes[7:0]}, w, 1'b1);
        grp_bytes = '0;
        grp_fill  = '0;
      end
    end else begin
      line_len = data_len();
      if (32'(line_pos) < line_len) begin
        if (32'(grp_fill) + 1 < group_len()) begin
          grp_bytes = grp_bytes | (32'(b) << (8 * grp_fill));
          grp_fill  = grp_fill + 1'b1;
        end else begin
          b0 = 16'(grp_bytes[7:0]);
          b1 = 16'(grp_bytes[15:8]);
          b2 = 16'(grp_bytes[23:16]);
          b3 = 16'(grp_bytes[31:24]);
          s  = '{default: '0};
          if (twelve_r && mode_r == MODE_MIPI) begin
            s[0] = (b0 << 4) | (bb & 16'hf);
            s[1] = (b1 << 4) | ((bb >> 4) & 16'hf);
          end else if (twelve_r) begin
            s[0] = b0 | ((b1 & 16'hf) << 8);
            s[1] = ((b1 >> 4) & 16'hf) | (bb << 4);
          end else if (mode_r == MODE_MIPI) begin
            s[0] = (b0 << 2) | (bb & 16'h3);
            s[1] = (b1 << 2) | ((bb >> 2) & 16'h3);
            s[2] = (b2 << 2) | ((bb >> 4) & 16'h3);
            s[3] = (b3 << 2) | ((bb >> 6) & 16'h3);
          end else begin
            s[0] = b0 | ((b1 & 16'h3) << 8);
            s[1] = ((b1 >> 2) & 16'h3f) | ((b2 & 16'hf) << 6);
            s[2] = ((b2 >> 4) & 16'hf) | ((b3 & 16'h3f) << 4);
            s[3] = ((b3 >> 6) & 16'h3) | (bb << 2);
          end
          for (int unsigned k = 0; k < group_samples(); k++)
            emit_sample(s[k], w, k == group_samples() - 1);
          grp_bytes = '0;
          grp_fill  = '0;
        end
      end
      // bytes past the data length are line padding
      nxt = 32'(line_pos) + 1;
      if (nxt >= padded_len()) nxt = 0;
      line_pos = nxt[13:0];
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 16);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    absorb_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  // bytes go out least significant first
  task automatic send_bytes(input logic [63:0] seq, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_byte(seq[8*i +: 8]);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    // a padding byte may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_PACK_MODE:    mode_r   = val[1:0];
      REG_DEPTH_TWELVE: twelve_r = val[0];
      REG_WIDTH:        width_r  = val;
      default:          height_r = val;
    endcase
  endtask

  task automatic write_settings(input logic [1:0] mode, input logic twelve,
                                input logic [13:0] width, input logic [13:0] height);
    settle();
    put_reg(REG_PACK_MODE, 14'(mode));
    put_reg(REG_DEPTH_TWELVE, 14'(twelve));
    put_reg(REG_WIDTH, width);
    put_reg(REG_HEIGHT, height);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // reset settings: MIPI ten-bit, 1920 wide
  task automatic test_default_config();
    send_bytes(64'hE4_FF_00_FF_00, 5);
  endtask

  // both packings and depths; oversized width and height saturate
  task automatic test_packed_modes();
    write_settings(MODE_LSB, 1'b1, 14'h3FFF, 14'h3FFF);
    send_bytes(64'hA5_0F_FF, 3);
    write_settings(MODE_LSB, 1'b0, 14'(MAX_WIDTH), 14'(MAX_HEIGHT));
    send_bytes(64'hFF_FE_7F_80_01, 5);
    write_settings(MODE_MIPI, 1'b1, 14'h3FFF, 14'd2);
    send_bytes(64'h3C_00_FF, 3);
  endtask

  // plain 16-bit, depth ignored, zero width and height raised to one, mode 3 aliasing
  task automatic test_plain_modes();
    write_settings(MODE_PLAIN, 1'b1, 14'd0, 14'd0);
    send_bytes(64'h1234, 2);
    write_settings(MODE_ALIAS_PLAIN, 1'b0, 14'd3, 14'd1);
    send_bytes(64'hFFFF_0000, 4);
  endtask

  // width 7 trims to one ten-bit group; the stale line count starts as padding
  task automatic test_width_trim();
    write_settings(MODE_MIPI, 1'b0, 14'd7, 14'd2);
    send_bytes(64'h1B_C3_5A_81_7E_99, 6);
  endtask

  task automatic test_random_frames();
    int unsigned sent, frame, n, pick;
    logic [1:0]  mode;
    logic        twelve;
    logic [13:0] width, height;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) mode = MODE_PLAIN;
      else if (pick == 1) mode = MODE_ALIAS_PLAIN;
      else if (pick < 6) mode = MODE_MIPI;
      else mode = MODE_LSB;
      twelve = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick == 0) width = 14'($urandom_range(0, 3));
      else if (pick == 1) width = ($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'(MAX_WIDTH);
      else width = 14'($urandom_range(2, 24));
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
        case ($urandom_range(0, 2))
          0:       height = 14'd0;
          1:       height = 14'(MAX_HEIGHT);
          default: height = 14'h3FFF;
        endcase
      end else begin
        height = 14'($urandom_range(1, 3));
      end
      write_settings(mode, twelve, width, height);
      frame = (mode_is_packed() ? padded_len() : 2 * active_width()) * frame_lines();
      // mostly whole frames, sometimes a cut-off stream
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 20);
      else n = (frame > FRAME_CAP) ? $urandom_range(16, FRAME_CAP) : frame;
      repeat (n) send_byte(8'($urandom));
      sent += n;
    end
  endtask

  function automatic void flag_field(input string field, input logic [15:0] want,
                                     input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_samples
    sample_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0h", $time,
                 out_ch.sample_value);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        flag_field("sample_value", want.value, out_ch.sample_value);
        flag_field("end_of_line", 16'(want.eol), 16'(out_ch.end_of_line));
        flag_field("end_of_frame", 16'(want.eof), 16'(out_ch.end_of_frame));
        flag_field("last_of_burst", 16'(want.last), 16'(out_ch.last_of_burst));
        samples_checked++;
        if (want.eol) lines_closed++;
        if (want.eof) frames_closed++;
      end
    end
  end

  // receiver back-pressure: switches between randomly chosen stall patterns
  initial begin : sink_stall
    int unsigned pattern, left, tick;
    left = 0;
    tick = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        pattern = $urandom_range(0, 3);
        left    = $urandom_range(16, 64);
      end
      left--;
      tick++;
      case (pattern)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 2) != 0);
        2:       out_ch.ready <= ((tick % 4) != 0);
        default: out_ch.ready <= ((tick % 12) < 6);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_PACK_MODE;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_config();
    test_packed_modes();
    test_plain_modes();
    test_width_trim();
    test_random_frames();
    settle();

    $display("Sent %0d bytes over %0d register settings; checked %0d samples",
             bytes_sent, settings_used, samples_checked);
    $display("with %0d line ends and %0d frame ends", lines_closed, frames_closed);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/prsu_pkg.sv
sv/prsu_if.sv
sv/prsu_front.sv
sv/prsu_queue.sv
sv/prsu_back.sv
sv/packed_raw_sample_unpacker.sv
sv/prsu_checker.sv
verif/tb_top.sv
